FILE: src/throttle_velocity_pi_control_macros.svh
// Assertion macros for the throttle velocity controller
`ifndef THROTTLE_VELOCITY_PI_CONTROL_MACROS_SVH
`define THROTTLE_VELOCITY_PI_CONTROL_MACROS_SVH
// assert that an implication holds, outside reset
`define TVPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// assert that a condition holds in the cycle after another
`define TVPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/tvpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tvpc_pkg;
    localparam int IntegWidth = 32;
    localparam int TimeWidth  = 32;

    localparam logic [2:0] RegMin      = 3'd0;
    localparam logic [2:0] RegNeutral  = 3'd1;
    localparam logic [2:0] RegMax      = 3'd2;
    localparam logic [2:0] RegKp       = 3'd3;
    localparam logic [2:0] RegKi       = 3'd4;
    localparam logic [2:0] RegRate     = 3'd5;
    localparam logic [2:0] RegAnalysis = 3'd6;
    localparam logic [2:0] RegProfile  = 3'd7;

    // feedforward slope and offset, index {profile, forward}
    function automatic logic [18:0] ff_slope(input logic [1:0] sel);
        logic [18:0] s;
        case (sel)
            2'b00:   s = 19'd364085;
            2'b01:   s = 19'd357728;
            2'b10:   s = 19'd168919;
            2'b11:   s = 19'd159816;
            default: s = 19'd0;
        endcase
        return s;
    endfunction

    function automatic logic [13:0] ff_offset(input logic [1:0] sel);
        logic [13:0] c;
        case (sel)
            2'b00:   c = 14'd6400;
            2'b01:   c = 14'd10821;
            2'b10:   c = 14'd6743;
            2'b11:   c = 14'd10698;
            default: c = 14'd0;
        endcase
        return c;
    endfunction

    // divider request and answer
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [12:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

FILE: src/tvpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle
module tvpc_div (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  tvpc_pkg::t_div_req      i_req,
    output tvpc_pkg::t_div_rsp      o_rsp
);
    logic [47:0] r_quo, n_quo;
    logic [13:0] r_rem, n_rem;
    logic [12:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [13:0] w_trial;

    always_comb begin
        w_trial = {r_rem[12:0], r_quo[47]};
        n_quo   = {r_quo[46:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem    = w_trial - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    // shift one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

FILE: src/throttle_velocity_pi_control.sv
`timescale 1ns / 1ps
// Channel   Direction  Signals
// in        sink       i_valid / o_ready, mode, emergency, target, speed, waypoint, time
// out       source     o_valid / i_ready, accel, feedforward, used velocity, sent flag
// cfg       sink       i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data
//
// A navigation item starts with the ramp step in S_RAMP, a positioning item at S_FF; the
// serial divider (one quotient bit per cycle) runs once for the integrator step, and the
// ramp step uses a reciprocal multiply, S_RAMP forming the product and S_RDIV scaling it.
// A zero used velocity skips the divider; an emergency item goes straight to S_OUT.
// Reset is synchronous; after reset the block is ready at once. The result waits in the
// output register; the next item is accepted only at or after the edge that takes it.
`default_nettype none
`include "throttle_velocity_pi_control_macros.svh"
module throttle_velocity_pi_control (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire                 i_mode,
    input  wire                 i_emergency,
    input  wire signed [12:0]   i_target_velocity,
    input  wire  [11:0]         i_measured_speed,
    input  wire  [15:0]         i_waypoint_id,
    input  wire  [31:0]         i_time_ms,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [15:0]         o_accel_stroke,
    output logic [15:0]         o_feedforward_stroke,
    output logic signed [12:0]  o_used_velocity,
    output logic                o_command_sent,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [2:0]          i_cfg_index,
    input  wire  [15:0]         i_cfg_data
);
    localparam int IW = tvpc_pkg::IntegWidth;
    localparam int TW = tvpc_pkg::TimeWidth;
    localparam logic signed [IW-1:0] IMax = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] IMin = {1'b1, {(IW-1){1'b0}}};

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RAMP  = 8'b0000_0010,
        S_RDIV  = 8'b0000_0100,
        S_FF    = 8'b0000_1000,
        S_IMUL  = 8'b0001_0000,
        S_IDIV  = 8'b0010_0000,
        S_SUM   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [15:0] r_min, r_neutral, r_max, r_kp, r_ki, r_rate;
    logic        r_analysis, r_profile;

    // controller state
    logic signed [12:0]   r_ramped;
    logic [TW-1:0]        r_ramp_time;
    logic [15:0]          r_last_wp;
    logic                 r_wp_valid;
    logic signed [IW-1:0] r_integ;

    // captured item
    logic signed [12:0]   r_target;
    logic [11:0]          r_speed;
    logic [15:0]          r_wp;
    logic [TW-1:0]        r_time;

    // working values
    logic signed [12:0]   r_v;
    logic signed [14:0]   r_dv;
    logic signed [17:0]   r_ff;
    logic [38:0]          r_prod;
    logic                 r_neg;
    logic signed [31:0]   r_pterm;

    // output register
    logic                 r_oval;
    logic [15:0]          r_o_accel, r_o_ff;
    logic signed [12:0]   r_o_v;
    logic                 r_o_sent;
    logic                 r_emg;

    tvpc_pkg::t_div_req   w_req;
    tvpc_pkg::t_div_rsp   w_rsp;

    tvpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    logic w_in_acc, w_cfg_acc;
    assign o_ready     = (r_state == S_IDLE) && (!r_oval || i_ready);
    assign w_in_acc    = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid;

    // ramp step combinational pieces
    logic [TW-1:0] w_dt;
    logic [22:0]   w_dtc;
    logic          w_newwp;
    logic [TW-1:0] w_rtime;
    always_comb begin
        w_newwp = !r_wp_valid || (r_wp != r_last_wp);
        w_rtime = w_newwp ? r_time : r_ramp_time;
        w_dt    = r_time - w_rtime;
        w_dtc   = (64'(w_dt) > 64'd8192000) ? 23'd8192000 : 23'(w_dt);
    end

    // apply ramp step: divide by 1000 through a reciprocal multiply
    logic [46:0]        w_recip;
    logic [13:0]        w_step;
    logic signed [14:0] w_up, w_dn;
    logic signed [12:0] w_rampv;
    always_comb begin
        w_recip = 47'(r_prod[22:0]) * 47'(24'd8589935);
        w_step  = (r_prod >= 39'd8192000) ? 14'd8192 : w_recip[46:33];
        w_up    = 15'(r_ramped) + $signed({1'b0, w_step});
        w_dn    = 15'(r_ramped) - $signed({1'b0, w_step});
        if (r_target > r_ramped)
            w_rampv = (w_up >= 15'(r_target)) ? r_target : w_up[12:0];
        else
            w_rampv = (w_dn <= 15'(r_target)) ? r_target : w_dn[12:0];
    end

    // feedforward
    logic [1:0]         w_sel;
    logic signed [33:0] w_ffp;
    logic signed [17:0] w_ffl;
    logic signed [17:0] w_ffc;
    always_comb begin
        w_sel = {r_profile, !r_v[12]};
        w_ffp = $signed({1'b0, tvpc_pkg::ff_slope(w_sel)}) * 34'(r_v) + 34'sd32768;
        w_ffl = 18'(w_ffp >>> 16) + $signed({4'd0, tvpc_pkg::ff_offset(w_sel)});
        w_ffc = w_ffl;
        if (r_v == 13'sd0) begin
            w_ffc = $signed({2'b0, r_neutral});
        end else if (r_v < 0) begin
            if (w_ffc > $signed({2'b0, r_neutral})) w_ffc = $signed({2'b0, r_neutral});
            if (w_ffc < $signed({2'b0, r_min}))     w_ffc = $signed({2'b0, r_min});
        end else begin
            if (w_ffc < $signed({2'b0, r_neutral})) w_ffc = $signed({2'b0, r_neutral});
            if (w_ffc > $signed({2'b0, r_max}))     w_ffc = $signed({2'b0, r_max});
        end
    end

    // error and magnitudes
    logic signed [14:0] w_dv;
    logic [14:0]        w_adv;
    logic [12:0]        w_mag;
    logic signed [31:0] w_kpdv;
    always_comb begin
        w_dv   = (r_v >= 0) ? 15'(r_v) - $signed({3'b0, r_speed})
                            : 15'(r_v) + $signed({3'b0, r_speed});
        w_adv  = w_dv[14] ? 15'(-w_dv) : w_dv;
        w_mag  = r_v[12] ? 13'(-r_v) : r_v;
        w_kpdv = $signed({16'd0, r_kp}) * 32'(r_dv);
    end

    // integrator update with saturation
    logic signed [49:0]   w_ni;
    logic signed [49:0]   w_istep;
    logic signed [IW-1:0] w_isat;
    always_comb begin
        w_istep = r_neg ? -$signed({2'b0, w_rsp.quo})
                        :  $signed({2'b0, w_rsp.quo});
        w_ni    = 50'(r_integ) + w_istep;
        if (w_ni > 50'(IMax))      w_isat = IMax;
        else if (w_ni < 50'(IMin)) w_isat = IMin;
        else                       w_isat = w_ni[IW-1:0];
    end

    // final sum and clamp, forced to neutral in analysis mode at low speed
    logic signed [51:0] w_pos;
    logic signed [51:0] w_posc;
    always_comb begin
        w_pos  = 52'(r_ff) + 52'(r_pterm) + 52'(r_integ);
        w_posc = w_pos;
        if (r_v >= 0) begin
            if (w_posc < 52'($signed({1'b0, r_neutral}))) w_posc = 52'(r_neutral);
            if (w_posc > 52'($signed({1'b0, r_max})))     w_posc = 52'(r_max);
        end else begin
            if (w_posc > 52'($signed({1'b0, r_neutral}))) w_posc = 52'(r_neutral);
            if (w_posc < 52'($signed({1'b0, r_min})))     w_posc = 52'(r_min);
        end
        if (r_analysis && ({4'd0, r_speed} * 16'd10 < 16'd1024))
            w_posc = 52'(r_neutral);
    end

    // divider launch for the integrator step
    always_comb begin
        w_req.start = (r_state == S_IMUL);
        w_req.num   = 48'(r_ki) * 48'(w_adv);
        w_req.den   = w_mag;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 16'd2560; r_neutral <= 16'd8960; r_max <= 16'd16384;
            r_kp <= 16'd256; r_ki <= 16'd0; r_rate <= 16'd512;
            r_analysis <= 1'b0; r_profile <= 1'b0;
        end else if (w_cfg_acc) begin
            case (i_cfg_index)
                tvpc_pkg::RegMin:      r_min      <= i_cfg_data;
                tvpc_pkg::RegNeutral:  r_neutral  <= i_cfg_data;
                tvpc_pkg::RegMax:      r_max      <= i_cfg_data;
                tvpc_pkg::RegKp:       r_kp       <= i_cfg_data;
                tvpc_pkg::RegKi:       r_ki       <= i_cfg_data;
                tvpc_pkg::RegRate:     r_rate     <= i_cfg_data;
                tvpc_pkg::RegAnalysis: r_analysis <= i_cfg_data[0];
                tvpc_pkg::RegProfile:  r_profile  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // emergency path marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_emg <= 1'b0;
        else if (w_in_acc)
            r_emg <= i_emergency;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oval      <= 1'b0;
            r_ramped    <= '0;
            r_ramp_time <= '0;
            r_last_wp   <= '0;
            r_wp_valid  <= 1'b0;
            r_integ     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_valid && i_ready) r_oval <= 1'b0;
                    if (w_in_acc) begin
                        r_target <= i_target_velocity;
                        r_speed  <= i_measured_speed;
                        r_wp     <= i_waypoint_id;
                        r_time   <= TW'(i_time_ms);
                        if (i_emergency) begin
                            r_o_accel <= r_neutral;
                            r_o_ff    <= '0;
                            r_o_v     <= '0;
                            r_o_sent  <= 1'b0;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= i_mode ? S_FF : S_RAMP;
                            r_v     <= i_target_velocity;
                        end
                    end
                end
                S_RAMP: begin
                    r_wp_valid <= 1'b1;
                    r_last_wp  <= r_wp;
                    r_prod     <= 39'(r_rate) * 39'(w_dtc);
                    if (r_target == r_ramped) begin
                        r_ramp_time <= w_rtime;
                        r_v         <= r_target;
                        r_state     <= S_FF;
                    end else begin
                        r_state <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    r_ramped    <= w_rampv;
                    r_ramp_time <= r_time;
                    r_v         <= w_rampv;
                    r_state     <= S_FF;
                end
                S_FF: begin
                    r_ff    <= w_ffc;
                    r_dv    <= w_dv;
                    r_neg   <= w_dv[14];
                    r_state <= (r_v == 13'sd0) ? S_SUM : S_IMUL;
                end
                S_IMUL: begin
                    r_state <= S_IDIV;
                end
                S_IDIV: begin
                    if (w_rsp.done) begin
                        r_integ <= w_isat;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    // truncate toward zero
                    r_pterm <= (w_kpdv < 0) ? -((-w_kpdv) >>> 10) : (w_kpdv >>> 10);
                    r_state <= S_OUT;
                    r_o_ff  <= r_ff[15:0];
                    r_o_v   <= r_v;
                    r_o_sent <= !r_analysis;
                end
                S_OUT: begin
                    if (!r_oval || i_ready) begin
                        if (!r_emg)
                            r_o_accel <= w_posc[15:0];
                        r_oval  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid              = r_oval;
    assign o_accel_stroke       = r_o_accel;
    assign o_feedforward_stroke = r_o_ff;
    assign o_used_velocity      = r_o_v;
    assign o_command_sent       = r_o_sent;

    `TVPC_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    `TVPC_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_in_acc, r_state != S_IDLE)
    `TVPC_ASSERT_IMP(a_div_idle_start, i_clk, i_rst_n, w_req.start, r_state == S_IMUL)
endmodule
`default_nettype wire
